@@ rtl/core/mpsc_pkg.sv @@
// shared types and constants for the mesh plane side classifier
`default_nettype none

package mpsc_pkg;

  // side class codes carried on the result word
  typedef enum logic [1:0] {
    CLASS_BEHIND = 2'd0,
    CLASS_FRONT  = 2'd1,
    CLASS_CROSS  = 2'd2
  } side_class_t;

  // configuration register index width and register map
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 4'd3;

  // vertex count of a triangle and coordinate count per triangle
  localparam int NUM_VERTS  = 3;
  localparam int NUM_COORDS = 9;

  // per-triangle sign summary handed from the evaluator to the class logic
  typedef struct packed {
    logic any_below;
    logic all_below;
  } side_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/mpsc_if.sv @@
// handshake interfaces for triangle, configuration and result channels
`default_nettype none

interface mpsc_tri_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] v0_x;
  logic signed [COORD_WIDTH-1:0] v0_y;
  logic signed [COORD_WIDTH-1:0] v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x;
  logic signed [COORD_WIDTH-1:0] v1_y;
  logic signed [COORD_WIDTH-1:0] v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x;
  logic signed [COORD_WIDTH-1:0] v2_y;
  logic signed [COORD_WIDTH-1:0] v2_z;
  logic                          last_triangle;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, last_triangle,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, last_triangle,
    output ready
  );
endinterface

interface mpsc_cfg_if #(
  parameter int COORD_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [mpsc_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_WIDTH-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface mpsc_cls_if;
  logic       valid;
  logic       ready;
  logic [1:0] side_class;

  modport source (output valid, side_class, input ready);
  modport sink   (input valid, side_class, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mesh_plane_side_classifier.sv @@
// top level: streaming triangle-versus-plane mesh classifier
//
// Classifies a mesh, streamed one triangle per word, against a plane held in
// four configuration registers (normal x/y/z and offset, signed fixed point
// with FRAC_BITS fraction bits). Each vertex distance n.p + offset is formed
// exactly, and only its sign is used: zero counts as in front. A sticky class
// starts at behind; while it is behind, a triangle wholly at or above zero makes
// it in front and a triangle that straddles zero makes it intersects. One result
// word is produced per mesh, on its last triangle, after which the class goes
// back to behind. Throughput is one triangle per cycle; a triangle passes the
// input register, the product register holding nine parallel multipliers, then
// the distance adders feeding the result register. Stages hold when the next is
// full, but a non-last triangle never waits on the result, so a held result only
// stalls the input once the two internal stages have filled. Configuration
// writes are always taken; indexes above the register map are ignored, and
// registers should only be written with no triangle in flight.
`default_nettype none

module mesh_plane_side_classifier #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input wire logic clk,
  input wire logic rst,
  mpsc_tri_if.sink   triangle,
  mpsc_cfg_if.sink   cfg,
  mpsc_cls_if.source result
);

  // configuration registers
  logic signed [COORD_WIDTH-1:0] normal [mpsc_pkg::NUM_VERTS];
  logic signed [COORD_WIDTH-1:0] plane_offset;

  // input register stage
  logic                          s1_valid;
  logic                          s1_last;
  logic signed [COORD_WIDTH-1:0] s1_coord [mpsc_pkg::NUM_COORDS];

  // product register stage
  logic                            s2_valid;
  logic                            s2_last;
  logic signed [2*COORD_WIDTH-1:0] s2_prod [mpsc_pkg::NUM_COORDS];

  // result register and sticky class
  logic                  out_valid;
  mpsc_pkg::side_class_t out_class;
  mpsc_pkg::side_class_t running_class;
  mpsc_pkg::side_class_t class_next;
  mpsc_pkg::side_flags_t flags;

  // stage handshakes
  logic out_free;
  logic s2_drain;
  logic s2_load;
  logic s1_load;
  logic out_load;

  assign out_free = !out_valid || result.ready;
  // a triangle that is not the last one leaves no result, so it never waits
  assign s2_drain = s2_valid && (!s2_last || out_free);
  assign s2_load  = s1_valid && (!s2_valid || s2_drain);
  assign s1_load  = triangle.valid && triangle.ready;
  assign out_load = s2_drain && s2_last;

  assign triangle.ready = !s1_valid || !s2_valid || s2_drain;
  assign cfg.ready      = 1'b1;

  assign result.valid      = out_valid;
  assign result.side_class = 2'(out_class);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0]    <= '0;
      normal[1]    <= '0;
      normal[2]    <= COORD_WIDTH'(1) << FRAC_BITS;
      plane_offset <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mpsc_pkg::REG_NORMAL_X:     normal[0]    <= cfg.data;
        mpsc_pkg::REG_NORMAL_Y:     normal[1]    <= cfg.data;
        mpsc_pkg::REG_NORMAL_Z:     normal[2]    <= cfg.data;
        mpsc_pkg::REG_PLANE_OFFSET: plane_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register: valid bit tracks occupancy, payload loads on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last     <= triangle.last_triangle;
      s1_coord[0] <= triangle.v0_x;
      s1_coord[1] <= triangle.v0_y;
      s1_coord[2] <= triangle.v0_z;
      s1_coord[3] <= triangle.v1_x;
      s1_coord[4] <= triangle.v1_y;
      s1_coord[5] <= triangle.v1_z;
      s1_coord[6] <= triangle.v2_x;
      s1_coord[7] <= triangle.v2_y;
      s1_coord[8] <= triangle.v2_z;
    end
  end

  // product stage
  mpsc_mult_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mult (
    .clk    (clk),
    .load   (s2_load),
    .coord  (s1_coord),
    .normal (normal),
    .prod   (s2_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (s2_drain) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_last <= s1_last;
    end
  end

  // distance sums and signs
  mpsc_side_eval #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_eval (
    .prod         (s2_prod),
    .plane_offset (plane_offset),
    .flags        (flags)
  );

  // sticky class: only a behind class can change
  always_comb begin
    class_next = running_class;
    if (running_class == mpsc_pkg::CLASS_BEHIND) begin
      if (!flags.any_below) begin
        class_next = mpsc_pkg::CLASS_FRONT;
      end else if (!flags.all_below) begin
        class_next = mpsc_pkg::CLASS_CROSS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_class <= mpsc_pkg::CLASS_BEHIND;
      out_valid     <= 1'b0;
    end else begin
      if (s2_drain) begin
        // last triangle closes the mesh and restarts the class
        running_class <= s2_last ? mpsc_pkg::CLASS_BEHIND : class_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class <= class_next;
    end
  end

  // a closed mesh always restarts at behind
  a_restart_behind: assert property (@(posedge clk) disable iff (rst)
    out_load |=> running_class == mpsc_pkg::CLASS_BEHIND)
    else $error("class not cleared after mesh end");

  // a set class holds until the mesh ends
  a_sticky_class: assert property (@(posedge clk) disable iff (rst)
    (running_class != mpsc_pkg::CLASS_BEHIND && !out_load)
    |=> running_class == $past(running_class))
    else $error("sticky class changed mid mesh");

  // both stages full and blocked means no new triangle
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !s2_drain) |-> !triangle.ready)
    else $error("triangle accepted with pipeline full");

  // a held result word is never overwritten by a new last triangle
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !out_load)
    else $error("result overwritten while held");

endmodule

`default_nettype wire

@@ rtl/core/mpsc_mult_stage.sv @@
// product register stage: normal components times vertex coordinates
`default_nettype none

module mpsc_mult_stage #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire logic signed [COORD_WIDTH-1:0]   coord [mpsc_pkg::NUM_COORDS],
  input  wire logic signed [COORD_WIDTH-1:0]   normal [mpsc_pkg::NUM_VERTS],
  output      logic signed [2*COORD_WIDTH-1:0] prod [mpsc_pkg::NUM_COORDS]
);

  logic signed [2*COORD_WIDTH-1:0] prod_next [mpsc_pkg::NUM_COORDS];

  // coordinate k is axis k%3 of vertex k/3
  always_comb begin
    for (int k = 0; k < mpsc_pkg::NUM_COORDS; k++) begin
      prod_next[k] = (2*COORD_WIDTH)'(coord[k])
                   * (2*COORD_WIDTH)'(normal[k % mpsc_pkg::NUM_VERTS]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mpsc_side_eval.sv @@
// distance sums and sign summary for one registered triangle
`default_nettype none

module mpsc_side_eval #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic signed [2*COORD_WIDTH-1:0] prod [mpsc_pkg::NUM_COORDS],
  input  wire logic signed [COORD_WIDTH-1:0]   plane_offset,
  output      mpsc_pkg::side_flags_t           flags
);

  // wide enough for three products and the scaled offset without overflow
  localparam int TERM_W = (2*COORD_WIDTH > COORD_WIDTH + FRAC_BITS)
                          ? 2*COORD_WIDTH : COORD_WIDTH + FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;

  logic signed [SUM_W-1:0] offset_term;
  logic signed [SUM_W-1:0] vert_dist [mpsc_pkg::NUM_VERTS];
  logic [mpsc_pkg::NUM_VERTS-1:0] below;

  assign offset_term = SUM_W'(plane_offset) <<< FRAC_BITS;

  always_comb begin
    for (int v = 0; v < mpsc_pkg::NUM_VERTS; v++) begin
      vert_dist[v] = SUM_W'(prod[3*v]) + SUM_W'(prod[3*v+1]) + SUM_W'(prod[3*v+2])
                   + offset_term;
      below[v] = vert_dist[v][SUM_W-1];
    end
  end

  assign flags.any_below = |below;
  assign flags.all_below = &below;

endmodule

`default_nettype wire

@@ verif/mesh_plane_side_classifier_test.sv @@
// self-checking testbench for the mesh plane side classifier
module mesh_plane_side_classifier_test;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  // wide enough to hold three exact products plus the scaled offset
  localparam int DIST_W      = 128;

  // run shape
  localparam int RESET_CYCLES    = 9;
  localparam int PIPE_SLACK      = 8;     // three-stage pipe plus margin
  localparam int STALL_LIMIT     = 3000;  // cycles with no handshake on any channel
  localparam int IDLE_PCT        = 31;
  localparam int RANDOM_WORDS    = 1000;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_OFF_AT     = 400;   // triangle count that starts the long result stall
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CALM_FIRST      = 650;   // triangle window with no idling on either side
  localparam int CALM_LAST       = 850;
  localparam int VERTEX_TRIES    = 24;

  typedef logic [mpsc_pkg::CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_UNUSED_FIRST = mpsc_pkg::REG_PLANE_OFFSET + 1'b1;
  localparam reg_idx_t REG_UNUSED_LAST  = '1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t Q_ONE     = coord_t'(1) << FRAC_BITS;

  // one triangle word: v0 xyz, v1 xyz, v2 xyz, then the end-of-mesh flag
  typedef struct {
    coord_t c [mpsc_pkg::NUM_COORDS];
    logic   last;
  } tri_word_t;

  // what a generated triangle should look like against the current plane
  typedef enum {TRI_BELOW, TRI_ABOVE, TRI_STRADDLE, TRI_NOISE} tri_kind_t;

  // plane copy, running mesh class and queue of classes still owed by the block
  class side_scoreboard;
    coord_t                normal_x;
    coord_t                normal_y;
    coord_t                normal_z;
    coord_t                plane_offset;
    mpsc_pkg::side_class_t mesh_class;
    mpsc_pkg::side_class_t owed_q[$];
    int unsigned           errors;

    function new();
      normal_x     = '0;
      normal_y     = '0;
      normal_z     = Q_ONE;
      plane_offset = '0;
      mesh_class   = mpsc_pkg::CLASS_BEHIND;
      errors       = 0;
    endfunction

    // indexes past the register map are dropped
    function void load_reg(reg_idx_t idx, coord_t value);
      case (idx)
        mpsc_pkg::REG_NORMAL_X:     normal_x = value;
        mpsc_pkg::REG_NORMAL_Y:     normal_y = value;
        mpsc_pkg::REG_NORMAL_Z:     normal_z = value;
        mpsc_pkg::REG_PLANE_OFFSET: plane_offset = value;
        default: ;
      endcase
    endfunction

    // exact sign of n.p + offset, zero counts as not below
    function bit vertex_below(coord_t x, coord_t y, coord_t z);
      logic signed [DIST_W-1:0] wx, wy, wz, nwx, nwy, nwz, woff, dsum;
      wx   = x;
      wy   = y;
      wz   = z;
      nwx  = normal_x;
      nwy  = normal_y;
      nwz  = normal_z;
      woff = plane_offset;
      dsum = nwx * wx + nwy * wy + nwz * wz + (woff <<< FRAC_BITS);
      return dsum[DIST_W-1];
    endfunction

    function void note_triangle(tri_word_t w);
      bit b0, b1, b2;
      // the class is sticky once it leaves behind
      if (mesh_class == mpsc_pkg::CLASS_BEHIND) begin
        b0 = vertex_below(w.c[0], w.c[1], w.c[2]);
        b1 = vertex_below(w.c[3], w.c[4], w.c[5]);
        b2 = vertex_below(w.c[6], w.c[7], w.c[8]);
        if (!(b0 || b1 || b2)) begin
          mesh_class = mpsc_pkg::CLASS_FRONT;
        end else if (!(b0 && b1 && b2)) begin
          mesh_class = mpsc_pkg::CLASS_CROSS;
        end
      end
      if (w.last) begin
        owed_q.push_back(mesh_class);
        mesh_class = mpsc_pkg::CLASS_BEHIND;
      end
    endfunction

    function void check_result(logic [1:0] got);
      mpsc_pkg::side_class_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: side_class expected none got %0d", $time, got);
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: side_class expected %0d (%s) got %0d", $time, want, want.name(), got);
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  // clock: 10 units, high then low
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mpsc_tri_if #(.COORD_WIDTH(COORD_WIDTH)) tri_bus ();
  mpsc_cfg_if #(.COORD_WIDTH(COORD_WIDTH)) cfg_bus ();
  mpsc_cls_if                              cls_bus ();

  mesh_plane_side_classifier #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .triangle(tri_bus),
    .cfg     (cfg_bus),
    .result  (cls_bus)
  );

  side_scoreboard sb = new();
  int unsigned tri_count = 0;  // triangle words accepted so far

  // coordinate mix: full range, near zero, corner values, whole units
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return coord_t'($urandom);
      5, 6: return coord_t'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      7: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return coord_t'(($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS);
    endcase
  endfunction

  // small whole-unit value for plane registers
  function automatic coord_t rand_unit();
    return coord_t'(($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS);
  endfunction

  // retry random vertices, up to VERTEX_TRIES more times, until one lands on the
  // wanted side; if none does (as with a zero normal) the last try is kept
  function automatic void pick_vertex(input bit want_below, output coord_t x,
                                      output coord_t y, output coord_t z);
    x = rand_coord();
    y = rand_coord();
    z = rand_coord();
    for (int t = 0; t < VERTEX_TRIES && sb.vertex_below(x, y, z) != want_below; t++) begin
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
    end
  endfunction

  function automatic tri_word_t make_triangle(tri_kind_t kind, logic last);
    tri_word_t w;
    int        lo_pos, hi_pos;
    bit        want;
    lo_pos = $urandom_range(0, 2);
    hi_pos = (lo_pos + 1 + $urandom_range(0, 1)) % mpsc_pkg::NUM_VERTS;
    for (int v = 0; v < mpsc_pkg::NUM_VERTS; v++) begin
      if (kind == TRI_NOISE) begin
        w.c[3*v]   = rand_coord();
        w.c[3*v+1] = rand_coord();
        w.c[3*v+2] = rand_coord();
      end else begin
        case (kind)
          TRI_BELOW: want = 1'b1;
          TRI_ABOVE: want = 1'b0;
          default:   want = (v == lo_pos) ? 1'b1 : (v == hi_pos) ? 1'b0 : 1'($urandom_range(0, 1));
        endcase
        pick_vertex(want, w.c[3*v], w.c[3*v+1], w.c[3*v+2]);
      end
    end
    w.last = last;
    return w;
  endfunction

  // fixed x/y corners, caller picks the three z values
  function automatic tri_word_t tri_z(coord_t z0, coord_t z1, coord_t z2, logic last);
    tri_word_t w;
    w.c    = '{COORD_MIN, COORD_MAX, z0, COORD_MAX, COORD_MIN, z1, '0, -1, z2};
    w.last = last;
    return w;
  endfunction

  // every coordinate of a vertex set to one value
  function automatic tri_word_t tri_verts(coord_t a, coord_t b, coord_t c, logic last);
    tri_word_t w;
    w.c    = '{a, a, a, b, b, b, c, c, c};
    w.last = last;
    return w;
  endfunction

  // offer one triangle word, idling at random first, and hold it until taken
  task automatic send_triangle(tri_word_t w);
    bit calm;
    calm = tri_count >= CALM_FIRST && tri_count < CALM_LAST;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      tri_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tri_bus.valid         <= 1'b1;
    tri_bus.v0_x          <= w.c[0];
    tri_bus.v0_y          <= w.c[1];
    tri_bus.v0_z          <= w.c[2];
    tri_bus.v1_x          <= w.c[3];
    tri_bus.v1_y          <= w.c[4];
    tri_bus.v1_z          <= w.c[5];
    tri_bus.v2_x          <= w.c[6];
    tri_bus.v2_y          <= w.c[7];
    tri_bus.v2_z          <= w.c[8];
    tri_bus.last_triangle <= w.last;
    @(posedge clk);
    while (!tri_bus.ready) @(posedge clk);
    sb.note_triangle(w);
    tri_count++;
  endtask

  // a mesh is mostly a run of behind triangles, then the one that decides the
  // class, then filler that must not change it; some meshes are pure noise
  task automatic send_mesh();
    int unsigned len, decide_at;
    tri_kind_t   target, kind;
    bit          noisy;
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
    decide_at = $urandom_range(0, len - 1);
    noisy     = $urandom_range(0, 99) < 15;
    case ($urandom_range(0, 2))
      0:       target = TRI_BELOW;
      1:       target = TRI_ABOVE;
      default: target = TRI_STRADDLE;
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy) begin
        kind = TRI_NOISE;
      end else if (i < decide_at) begin
        kind = TRI_BELOW;
      end else if (i == decide_at || target == TRI_BELOW) begin
        kind = target;
      end else begin
        kind = TRI_NOISE;
      end
      send_triangle(make_triangle(kind, i == len - 1));
    end
  endtask

  task automatic cfg_write(reg_idx_t idx, coord_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.load_reg(idx, value);
  endtask

  // all four plane registers plus one write to an index past the map
  task automatic set_plane(coord_t nx, coord_t ny, coord_t nz, coord_t off);
    cfg_write(reg_idx_t'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              coord_t'($urandom));
    cfg_write(mpsc_pkg::REG_NORMAL_X, nx);
    cfg_write(mpsc_pkg::REG_NORMAL_Y, ny);
    cfg_write(mpsc_pkg::REG_NORMAL_Z, nz);
    cfg_write(mpsc_pkg::REG_PLANE_OFFSET, off);
    cfg_bus.valid <= 1'b0;
  endtask

  // stop offering, wait out owed classes, then let non-last words retire
  task automatic wait_drained();
    tri_bus.valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off while triangles keep coming,
  // and a calm window with ready held high
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    cls_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && cls_bus.valid && cls_bus.ready) begin
        sb.check_result(cls_bus.side_class);
      end
      if (!hold_done && tri_count >= HOLD_OFF_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cls_bus.ready <= 1'b0;
      end else if (tri_count >= CALM_FIRST && tri_count < CALM_LAST) begin
        cls_bus.ready <= 1'b1;
      end else begin
        cls_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: too long with no word moving on any channel ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((tri_bus.valid && tri_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
          (cls_bus.valid && cls_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_start;
    rst                   <= 1'b1;
    tri_bus.valid         <= 1'b0;
    tri_bus.v0_x          <= '0;
    tri_bus.v0_y          <= '0;
    tri_bus.v0_z          <= '0;
    tri_bus.v1_x          <= '0;
    tri_bus.v1_y          <= '0;
    tri_bus.v1_z          <= '0;
    tri_bus.v2_x          <= '0;
    tri_bus.v2_y          <= '0;
    tri_bus.v2_z          <= '0;
    tri_bus.last_triangle <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset plane (z normal, no offset): zero distance, all behind, full straddle
    send_triangle(tri_z('0, '0, '0, 1'b1));
    send_triangle(tri_z(-1, -1, -1, 1'b1));
    send_triangle(tri_z(COORD_MIN, COORD_MAX, '0, 1'b1));
    // class set to in front early, later triangles must not move it
    send_triangle(tri_z(COORD_MIN, -1, COORD_MIN, 1'b0));
    send_triangle(tri_z(-1, -Q_ONE, COORD_MIN, 1'b0));
    send_triangle(tri_z(COORD_MAX, '0, Q_ONE, 1'b0));
    send_triangle(tri_z(COORD_MIN, COORD_MAX, -1, 1'b1));
    // straddle decides, a later front triangle is ignored
    send_triangle(tri_z(-1, -1, -1, 1'b0));
    send_triangle(tri_z(-1, Q_ONE, -1, 1'b0));
    send_triangle(tri_z(Q_ONE, Q_ONE, Q_ONE, 1'b1));
    // mesh that never leaves behind
    send_triangle(tri_z(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    send_triangle(tri_z(-1, -Q_ONE, COORD_MIN, 1'b0));
    send_triangle(tri_z(-Q_ONE, -1, -1, 1'b1));
    wait_drained();

    // most negative everywhere: the sum of products overflows 64 bits
    set_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_triangle(tri_verts(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    send_triangle(tri_verts(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_triangle(tri_verts(COORD_MIN, COORD_MAX, '0, 1'b1));
    wait_drained();

    // most positive everywhere
    set_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_triangle(tri_verts(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_triangle(tri_verts(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    send_triangle(tri_verts(COORD_MIN, '0, COORD_MAX, 1'b1));
    wait_drained();

    // zero normal: only the offset sign matters
    set_plane('0, '0, '0, -1);
    send_triangle(tri_verts(COORD_MAX, COORD_MIN, '0, 1'b1));
    wait_drained();
    set_plane('0, '0, '0, '0);
    send_triangle(tri_verts(COORD_MAX, COORD_MIN, '0, 1'b1));
    wait_drained();

    // random meshes, one plane setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       set_plane('0, '0, Q_ONE, '0);
        1:       set_plane(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                           coord_t'($urandom));
        2:       set_plane(rand_unit(), rand_unit(), rand_unit(), rand_unit());
        3:       set_plane(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        4:       set_plane('0, '0, '0, coord_t'($urandom));
        default: set_plane(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                           COORD_MIN);
      endcase
      phase_start = tri_count;
      while (tri_count - phase_start < RANDOM_WORDS / NUM_PHASES) begin
        send_mesh();
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
